/* rtl/square_tone_channel_with_length_counter_defines.svh */
// ----------------------------------------------------------------------------
// Square tone channel assertion macros
// Shared concurrent assertion forms used by the channel RTL.
// ----------------------------------------------------------------------------
`ifndef SQUARE_TONE_CHANNEL_WITH_LENGTH_COUNTER_DEFINES_SVH
`define SQUARE_TONE_CHANNEL_WITH_LENGTH_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stc assertion failed");

`endif

/* rtl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// Square tone channel package
// Transaction types, address and opcode codes, and lookup tables.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [15:0] ADDR_CONTROL   = 16'h4000;
    localparam logic [15:0] ADDR_PERIOD_LO = 16'h4002;
    localparam logic [15:0] ADDR_PERIOD_HI = 16'h4003;
    localparam logic [15:0] ADDR_STATUS    = 16'h4015;

    localparam logic [7:0] SILENT_LEVEL = 8'h80;
    localparam logic [7:0] CPS_RESET    = 8'd40;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Control byte bit positions
    localparam int HALT_BIT      = 5;
    localparam int CONST_VOL_BIT = 4;

    // APB register index
    localparam logic REG_CPS = 1'b0;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        frame_start;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  sample_level;
        logic        read_data;
    } t_out_item;

    function automatic logic [6:0] len_lookup(input logic [4:0] idx);
        logic [6:0] v;
        case (idx)
            5'd0:  v = 7'h05;  5'd1:  v = 7'h7F;  5'd2:  v = 7'h0A;  5'd3:  v = 7'h01;
            5'd4:  v = 7'h13;  5'd5:  v = 7'h02;  5'd6:  v = 7'h28;  5'd7:  v = 7'h03;
            5'd8:  v = 7'h50;  5'd9:  v = 7'h04;  5'd10: v = 7'h1E;  5'd11: v = 7'h05;
            5'd12: v = 7'h07;  5'd13: v = 7'h06;  5'd14: v = 7'h0D;  5'd15: v = 7'h07;
            5'd16: v = 7'h06;  5'd17: v = 7'h08;  5'd18: v = 7'h0C;  5'd19: v = 7'h09;
            5'd20: v = 7'h18;  5'd21: v = 7'h0A;  5'd22: v = 7'h30;  5'd23: v = 7'h0B;
            5'd24: v = 7'h60;  5'd25: v = 7'h0C;  5'd26: v = 7'h24;  5'd27: v = 7'h0D;
            5'd28: v = 7'h08;  5'd29: v = 7'h0E;  5'd30: v = 7'h10;  default: v = 7'h0F;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] duty_pos(input logic [1:0] sel);
        logic [3:0] v;
        case (sel)
            2'd0:    v = 4'd2;
            2'd1:    v = 4'd4;
            2'd2:    v = 4'd8;
            default: v = 4'd12;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] duty_neg(input logic [1:0] sel);
        logic [3:0] v;
        case (sel)
            2'd0:    v = 4'd14;
            2'd1:    v = 4'd12;
            2'd2:    v = 4'd8;
            default: v = 4'd4;
        endcase
        return v;
    endfunction

endpackage

/* rtl/square_tone_channel_with_length_counter.sv */
// ----------------------------------------------------------------------------
// Square tone channel with length counter
// Pulse-wave voice with duty sequencer, length counter and status readback.
// ----------------------------------------------------------------------------
// The channel takes one transaction per clock cycle while it is ready: sample
// ticks, bus writes and bus reads are each finished in the cycle they are
// accepted, with all state updated at that edge. A tick or a read yields one
// result transaction, registered into the output register or the skid entry;
// a write yields none. Results pass through an output register backed by one
// skid entry, so the input stays ready while a single result waits downstream
// and only drops ready once two results are pending. Configuration
// (cycles_per_sample, byte address 0) is written over the APB-style port.
// ----------------------------------------------------------------------------
module square_tone_channel_with_length_counter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input transaction channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stc_pkg::t_in_item   i_in_data,
    // Result transaction channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stc_pkg::t_out_item  o_out_data,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import stc_pkg::*;

    logic      accept;
    logic      has_result;
    logic      can_push;
    logic [7:0] cps;
    t_out_item result;

    // Accept whenever the result stage has room for one more transaction
    assign o_in_ready = can_push;
    assign accept     = i_in_valid && can_push;

    stc_apb u_apb (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .o_cycles_per_sample (cps)
    );

    // Compute the next state and result for the incoming transaction
    stc_voice u_voice (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_item              (i_in_data),
        .i_cycles_per_sample (cps),
        .o_has_result        (has_result),
        .o_result            (result)
    );

    // Hold results until the consumer takes them
    stc_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept && has_result),
        .i_data      (result),
        .o_can_push  (can_push),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/stc_apb.sv */
// ----------------------------------------------------------------------------
// Square tone channel configuration port
// APB-style slave holding the cycles-per-sample register.
// ----------------------------------------------------------------------------
module stc_apb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_cycles_per_sample
);
    import stc_pkg::*;

    logic [7:0] r_cps;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cps <= CPS_RESET;
        end else if (wr_en) begin
            r_cps <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CPS) begin
            prdata = {24'd0, r_cps};
        end
    end

    assign o_cycles_per_sample = r_cps;

endmodule

/* rtl/stc_voice.sv */
// ----------------------------------------------------------------------------
// Square tone channel voice
// Register state, phase/duty update and bus decode for one transaction.
// ----------------------------------------------------------------------------
module stc_voice (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  stc_pkg::t_in_item   i_item,
    input  logic [7:0]          i_cycles_per_sample,
    output logic                o_has_result,
    output stc_pkg::t_out_item  o_result
);
    import stc_pkg::*;

    logic [7:0]  r_control, n_control;
    logic [7:0]  r_period_lo, n_period_lo;
    logic [7:0]  r_period_hi, n_period_hi;
    logic [6:0]  r_length, n_length;
    logic [6:0]  r_saved, n_saved;
    logic [11:0] r_phase, n_phase;
    logic [11:0] r_latched, n_latched;
    logic [3:0]  r_duty, n_duty;
    logic        r_polarity, n_polarity;
    logic [7:0]  r_level, n_level;
    logic        r_armed, n_armed;

    logic [1:0]  sel;
    logic        armed;
    logic [6:0]  len_dec;

    assign sel   = r_control[7:6];
    assign armed = r_armed | i_item.frame_start;
    assign len_dec = (!r_control[HALT_BIT] && (r_length != 7'd0)) ? r_length - 7'd1 : r_length;

    always_comb begin
        n_control  = r_control;
        n_period_lo = r_period_lo;
        n_period_hi = r_period_hi;
        n_length   = r_length;
        n_saved    = r_saved;
        n_phase    = r_phase;
        n_latched  = r_latched;
        n_duty     = r_duty;
        n_polarity = r_polarity;
        n_level    = r_level;
        n_armed    = r_armed;
        o_has_result = 1'b0;
        o_result     = '0;
        case (i_item.opcode)
            OP_TICK: begin
                n_armed = armed;
                if (r_phase < r_latched) begin
                    n_phase = r_phase + {4'd0, i_cycles_per_sample};
                end else if (r_duty != 4'd0) begin
                    n_duty  = r_duty - 4'd1;
                    n_phase = r_phase - r_latched;
                end else if (r_polarity && armed) begin
                    // Recalculate: phase restarts at zero and then advances once
                    n_armed    = 1'b0;
                    n_polarity = 1'b0;
                    n_length   = len_dec;
                    n_latched  = {1'b0, r_period_hi[2:0], r_period_lo} + 12'd1;
                    n_duty     = duty_pos(sel);
                    n_phase    = {4'd0, i_cycles_per_sample};
                    if (!r_control[CONST_VOL_BIT] && (len_dec == 7'd0)) begin
                        n_level = SILENT_LEVEL;
                    end else begin
                        n_level = {1'b0, r_control[3:0], 3'b000};
                    end
                end else begin
                    n_duty     = r_polarity ? duty_pos(sel) : duty_neg(sel);
                    n_level    = 8'd0 - r_level;
                    n_polarity = ~r_polarity;
                    n_phase    = r_phase - r_latched;
                end
                o_has_result          = 1'b1;
                o_result.result_kind  = KIND_SAMPLE;
                o_result.sample_level = n_level;
            end
            OP_WRITE: begin
                if (i_item.bus_address == ADDR_CONTROL) begin
                    n_control = i_item.write_data;
                end else if (i_item.bus_address == ADDR_PERIOD_LO) begin
                    n_period_lo = i_item.write_data;
                end else if (i_item.bus_address == ADDR_PERIOD_HI) begin
                    n_period_hi = i_item.write_data;
                    n_length    = len_lookup(i_item.write_data[7:3]);
                end else if (i_item.bus_address == ADDR_STATUS) begin
                    if (i_item.write_data[0]) begin
                        n_length = r_saved;
                    end else begin
                        n_saved  = r_length;
                        n_length = 7'd0;
                    end
                end
            end
            OP_READ: begin
                o_has_result         = 1'b1;
                o_result.result_kind = KIND_READ;
                o_result.read_data   = (i_item.bus_address == ADDR_STATUS)
                                       && (r_length != 7'd0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control   <= '0;
            r_period_lo <= '0;
            r_period_hi <= '0;
            r_length    <= '0;
            r_saved     <= '0;
            r_phase     <= '0;
            r_latched   <= '0;
            r_duty      <= '0;
            r_polarity  <= 1'b0;
            r_level     <= SILENT_LEVEL;
            r_armed     <= 1'b0;
        end else if (i_accept) begin
            r_control   <= n_control;
            r_period_lo <= n_period_lo;
            r_period_hi <= n_period_hi;
            r_length    <= n_length;
            r_saved     <= n_saved;
            r_phase     <= n_phase;
            r_latched   <= n_latched;
            r_duty      <= n_duty;
            r_polarity  <= n_polarity;
            r_level     <= n_level;
            r_armed     <= n_armed;
        end
    end

endmodule

/* rtl/stc_skid.sv */
// ----------------------------------------------------------------------------
// Square tone channel result stage
// Output register plus one skid entry; input is refused only while the skid is full.
// ----------------------------------------------------------------------------
module stc_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  stc_pkg::t_out_item  i_data,
    output logic                o_can_push,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stc_pkg::t_out_item  o_out_data
);
    import stc_pkg::*;

`include "square_tone_channel_with_length_counter_defines.svh"

    logic      r_out_vld, r_skid_vld;
    t_out_item r_out_data, r_skid_data;
    logic      pop;

    assign pop        = r_out_vld && i_out_ready;
    assign o_can_push = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_vld || pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (!r_out_vld || pop) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    `STC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    `STC_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_vld && pop, r_out_vld && !r_skid_vld)
    `STC_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_push && !r_skid_vld && !r_out_vld, r_out_vld && (r_out_data == $past(i_data)))

endmodule

/* verif/square_tone_channel_with_length_counter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Square tone channel testbench
// Drives ticks, bus writes and bus reads through the channel with random
// idling on both sides, and predicts every sample and status read in step.
// A short table of directed transactions comes first, then random traffic
// over several sample-rate settings, with a long output hold-off and a
// mid-phase drain pause.
// ----------------------------------------------------------------------------
module square_tone_channel_with_length_counter_test;

    import stc_pkg::*;

    // Opcode the channel must ignore without producing a result
    localparam logic [1:0]  OP_UNUSED         = 2'd3;
    localparam logic [15:0] ADDR_LOWEST       = 16'h0000;
    localparam logic [15:0] ADDR_HIGHEST      = 16'hFFFF;
    localparam logic [15:0] ADDR_BELOW_STATUS = 16'h4014;
    localparam logic [2:0]  RATE_ADDR         = {REG_CPS, 2'b00};

    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 200;
    localparam int RANDOM_RATE_PHASE = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 5000;

    // Sample rate per phase; the random-rate phase draws its own
    localparam logic [7:0] PHASE_RATE [NUM_PHASES] =
        '{8'd255, 8'd1, 8'd40, 8'd9, 8'd40, 8'd128, 8'd2, 8'd255};
    // Idling modes: none, sender, receiver, both
    localparam int IN_IDLE_PCT   [4] = '{0, 57, 0, 20};
    localparam int OUT_STALL_PCT [4] = '{0, 0, 57, 20};

    // Length counter load values, indexed by write_data[7:3]
    localparam logic [6:0] LENGTH_LOAD [32] = '{
        7'h05, 7'h7F, 7'h0A, 7'h01, 7'h13, 7'h02, 7'h28, 7'h03,
        7'h50, 7'h04, 7'h1E, 7'h05, 7'h07, 7'h06, 7'h0D, 7'h07,
        7'h06, 7'h08, 7'h0C, 7'h09, 7'h18, 7'h0A, 7'h30, 7'h0B,
        7'h60, 7'h0C, 7'h24, 7'h0D, 7'h08, 7'h0E, 7'h10, 7'h0F
    };
    // Duty step counts for the first and second half of the wave
    localparam logic [3:0] DUTY_FIRST  [4] = '{4'd2, 4'd4, 4'd8, 4'd12};
    localparam logic [3:0] DUTY_SECOND [4] = '{4'd14, 4'd12, 4'd8, 4'd4};

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_directed_row;

    localparam int NUM_DIRECTED = 25;
    // Expected results are typed only for the reset state and unmapped reads;
    // the rest of the table is checked against the predictor.
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{OP_READ,   1'b0, ADDR_STATUS,       8'h00}, 1'b1, '{KIND_READ, 8'h00, 1'b0}},
        '{'{OP_TICK,   1'b0, ADDR_LOWEST,       8'h00}, 1'b1,
          '{KIND_SAMPLE, SILENT_LEVEL, 1'b0}},
        '{'{OP_READ,   1'b0, ADDR_HIGHEST,      8'hFF}, 1'b1, '{KIND_READ, 8'h00, 1'b0}},
        '{'{OP_WRITE,  1'b0, ADDR_CONTROL,      8'hFF}, 1'b0, '0},
        '{'{OP_WRITE,  1'b0, ADDR_PERIOD_LO,    8'h00}, 1'b0, '0},
        '{'{OP_WRITE,  1'b0, ADDR_PERIOD_HI,    8'hF8}, 1'b0, '0},
        '{'{OP_READ,   1'b0, ADDR_STATUS,       8'h00}, 1'b0, '0},
        '{'{OP_WRITE,  1'b0, ADDR_STATUS,       8'h00}, 1'b0, '0},
        '{'{OP_READ,   1'b0, ADDR_STATUS,       8'h00}, 1'b0, '0},
        '{'{OP_WRITE,  1'b0, ADDR_STATUS,       8'h01}, 1'b0, '0},
        '{'{OP_READ,   1'b0, ADDR_STATUS,       8'h00}, 1'b0, '0},
        '{'{OP_TICK,   1'b1, ADDR_LOWEST,       8'h00}, 1'b0, '0},
        '{'{OP_TICK,   1'b0, ADDR_HIGHEST,      8'hFF}, 1'b0, '0},
        '{'{OP_TICK,   1'b0, ADDR_LOWEST,       8'h00}, 1'b0, '0},
        '{'{OP_UNUSED, 1'b1, ADDR_HIGHEST,      8'hFF}, 1'b0, '0},
        '{'{OP_WRITE,  1'b0, ADDR_LOWEST,       8'hFF}, 1'b0, '0},
        '{'{OP_WRITE,  1'b1, ADDR_PERIOD_HI,    8'h0F}, 1'b0, '0},
        '{'{OP_WRITE,  1'b0, ADDR_PERIOD_LO,    8'hFF}, 1'b0, '0},
        '{'{OP_WRITE,  1'b1, ADDR_CONTROL,      8'h00}, 1'b0, '0},
        '{'{OP_READ,   1'b1, ADDR_BELOW_STATUS, 8'h00}, 1'b0, '0},
        '{'{OP_TICK,   1'b1, ADDR_LOWEST,       8'h00}, 1'b0, '0},
        '{'{OP_TICK,   1'b0, ADDR_LOWEST,       8'h00}, 1'b0, '0},
        '{'{OP_WRITE,  1'b0, ADDR_STATUS,       8'hFE}, 1'b0, '0},
        '{'{OP_READ,   1'b0, ADDR_STATUS,       8'h00}, 1'b0, '0},
        '{'{OP_TICK,   1'b0, ADDR_LOWEST,       8'h00}, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // DUT signals; the inputs are known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // Typed expectation travelling with the transaction on the input channel
    logic        row_typed   = 1'b0;
    t_out_item   row_want    = '0;

    // ------------------------------------------------------------------------
    // Predicted channel state
    // ------------------------------------------------------------------------
    logic [7:0]  ch_cps;
    logic [7:0]  ch_ctrl;
    logic [7:0]  ch_freq_lo;
    logic [7:0]  ch_freq_hi;
    logic [6:0]  ch_len;
    logic [6:0]  ch_len_saved;
    logic [11:0] ch_phase;
    logic [11:0] ch_wavelen;
    logic [3:0]  ch_duty_cnt;
    logic        ch_negative;
    logic [7:0]  ch_level;
    logic        ch_recalc_pending;

    t_out_item   queued_results [$];

    int error_count     = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int recalcs_seen    = 0;
    int live_status     = 0;
    int rates_written   = 0;
    int quiet_cycles    = 0;
    int in_idle_pct     = 0;
    int out_stall_pct   = 0;
    bit long_hold_req   = 1'b0;

    square_tone_channel_with_length_counter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted transaction to the channel state and
    // return 1 with the result when the transaction produces one.
    // ------------------------------------------------------------------------
    function automatic bit tone_channel_step(input t_in_item stim, output t_out_item res);
        logic [1:0] duty_sel;
        bit         produced;
        duty_sel = ch_ctrl[7:6];
        produced = 1'b0;
        res      = '0;
        case (stim.opcode)
            OP_TICK: begin
                if (stim.frame_start) ch_recalc_pending = 1'b1;
                if (ch_phase < ch_wavelen) begin
                    ch_phase = ch_phase + 12'(ch_cps);
                end else if (ch_duty_cnt != 4'd0) begin
                    ch_duty_cnt = ch_duty_cnt - 4'd1;
                    ch_phase    = ch_phase - ch_wavelen;
                end else if (ch_negative && ch_recalc_pending) begin
                    // End of the negative half after a frame start: reload the
                    // wave, step the length counter and pick the new level.
                    recalcs_seen++;
                    ch_negative       = 1'b0;
                    ch_recalc_pending = 1'b0;
                    if (!ch_ctrl[HALT_BIT] && ch_len != 7'd0) ch_len = ch_len - 7'd1;
                    ch_wavelen  = {1'b0, ch_freq_hi[2:0], ch_freq_lo} + 12'd1;
                    ch_duty_cnt = DUTY_FIRST[duty_sel];
                    if (!ch_ctrl[CONST_VOL_BIT] && ch_len == 7'd0) ch_level = SILENT_LEVEL;
                    else ch_level = {1'b0, ch_ctrl[3:0], 3'b000};
                    // Phase restarts at zero, below any reloaded wavelength
                    ch_phase = 12'(ch_cps);
                end else begin
                    ch_duty_cnt = ch_negative ? DUTY_FIRST[duty_sel] : DUTY_SECOND[duty_sel];
                    ch_level    = 8'd0 - ch_level;
                    ch_negative = !ch_negative;
                    ch_phase    = ch_phase - ch_wavelen;
                end
                res.result_kind  = KIND_SAMPLE;
                res.sample_level = ch_level;
                produced = 1'b1;
            end
            OP_WRITE: begin
                case (stim.bus_address)
                    ADDR_CONTROL:   ch_ctrl    = stim.write_data;
                    ADDR_PERIOD_LO: ch_freq_lo = stim.write_data;
                    ADDR_PERIOD_HI: begin
                        ch_freq_hi = stim.write_data;
                        ch_len     = LENGTH_LOAD[stim.write_data[7:3]];
                    end
                    ADDR_STATUS: begin
                        if (stim.write_data[0]) begin
                            ch_len = ch_len_saved;
                        end else begin
                            ch_len_saved = ch_len;
                            ch_len       = 7'd0;
                        end
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                res.result_kind = KIND_READ;
                res.read_data   = (stim.bus_address == ADDR_STATUS) && (ch_len != 7'd0);
                if (res.read_data) live_status++;
                produced = 1'b1;
            end
            default: ;
        endcase
        return produced;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: predict on input acceptance, compare on output acceptance.
    // Push before pop so a same-edge pair is handled in order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_out_item predicted;
        t_out_item want;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                items_taken++;
                if (tone_channel_step(i_in_data, predicted))
                    queued_results.push_back(row_typed ? row_want : predicted);
            end
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (queued_results.size() == 0) begin
                    error_count++;
                    $display("%0t: expected no result, got kind=%0b level=%02h status=%0b",
                             $time, o_out_data.result_kind, o_out_data.sample_level,
                             o_out_data.read_data);
                end else begin
                    want = queued_results.pop_front();
                    if (o_out_data.result_kind !== want.result_kind ||
                        o_out_data.sample_level !== want.sample_level ||
                        o_out_data.read_data !== want.read_data) begin
                        error_count++;
                        $write("%0t: mismatch expected kind=%0b level=%02h status=%0b,",
                               $time, want.result_kind, want.sample_level, want.read_data);
                        $display(" got kind=%0b level=%02h status=%0b",
                                 o_out_data.result_kind, o_out_data.sample_level,
                                 o_out_data.read_data);
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    // Abort when the channel stops moving transactions for too long
    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: no transaction moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls per phase, plus a long hold-off on request that
    // lets the channel fill up and push back on its input.
    // ------------------------------------------------------------------------
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    // Offer one transaction after a random idle gap; return at the accepting edge
    task automatic push_item(input t_in_item stim, input logic typed, input t_out_item want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= stim;
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle_channel();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (queued_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the sample rate over APB, then read it back
    task automatic program_rate(input logic [7:0] rate);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RATE_ADDR;
        pwdata  <= {24'd0, rate};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ch_cps = rate;
        rates_written++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {24'd0, rate}) begin
            error_count++;
            $display("%0t: rate readback expected %08h, got %08h", $time, {24'd0, rate}, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_in_item   stim;
        int         pick;
        int         phase_items;
        int         mode;
        logic [7:0] rate;
        logic       mapped;

        // Channel state right after reset
        ch_cps            = CPS_RESET;
        ch_ctrl           = '0;
        ch_freq_lo        = '0;
        ch_freq_hi        = '0;
        ch_len            = '0;
        ch_len_saved      = '0;
        ch_phase          = '0;
        ch_wavelen        = '0;
        ch_duty_cnt       = '0;
        ch_negative       = 1'b0;
        ch_level          = SILENT_LEVEL;
        ch_recalc_pending = 1'b0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset rate, no idling
        for (int r = 0; r < NUM_DIRECTED; r++)
            push_item(DIRECTED_ROWS[r].stim, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_channel();
            rate = PHASE_RATE[p];
            if (p == RANDOM_RATE_PHASE) rate = 8'($urandom_range(255, 1));
            program_rate(rate);
            mode          = p % 4;
            in_idle_pct   = IN_IDLE_PCT[mode];
            out_stall_pct = OUT_STALL_PCT[mode];

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                // Mostly well-formed register traffic and ticks; the rest is
                // noise across the whole address space and the unused opcode.
                stim.bus_address = 16'($urandom);
                stim.write_data  = 8'($urandom);
                stim.frame_start = ($urandom_range(7) == 0);
                pick = $urandom_range(99);
                if (pick < 62) begin
                    stim.opcode      = OP_TICK;
                    stim.frame_start = ($urandom_range(11) == 0);
                end else if (pick < 84) begin
                    stim.opcode = OP_WRITE;
                    case ($urandom_range(9))
                        0, 1: stim.bus_address = ADDR_CONTROL;
                        2, 3: begin
                            stim.bus_address = ADDR_PERIOD_LO;
                            if ($urandom_range(1) == 0) stim.write_data = 8'($urandom_range(15));
                        end
                        4, 5: begin
                            // Keep most wavelengths short so the duty counter turns over
                            stim.bus_address = ADDR_PERIOD_HI;
                            if ($urandom_range(3) != 0) stim.write_data[2:0] = 3'b000;
                        end
                        6, 7: stim.bus_address = ADDR_STATUS;
                        8: stim.bus_address = ADDR_CONTROL + 16'($urandom_range(31));
                        default: ;
                    endcase
                end else if (pick < 97) begin
                    stim.opcode = OP_READ;
                    if ($urandom_range(9) < 7) stim.bus_address = ADDR_STATUS;
                    else if ($urandom_range(1) == 0)
                        stim.bus_address = ADDR_CONTROL + 16'($urandom_range(31));
                end else begin
                    stim.opcode = OP_UNUSED;
                end

                push_item(stim, 1'b0, '0);

                // Count only transactions that can change state or produce a result
                mapped = (stim.bus_address == ADDR_CONTROL) ||
                         (stim.bus_address == ADDR_PERIOD_LO) ||
                         (stim.bus_address == ADDR_PERIOD_HI) ||
                         (stim.bus_address == ADDR_STATUS);
                if (stim.opcode != OP_UNUSED && !(stim.opcode == OP_WRITE && !mapped)) begin
                    phase_items++;
                    // Hold the output off while the sender keeps going
                    if (p == 0 && phase_items == 40) long_hold_req = 1'b1;
                    // Pause the sender until the channel has drained
                    if (p == 1 && phase_items == 100) settle_channel();
                end
            end
        end

        settle_channel();

        $display("Run covered %0d input transactions and %0d checked results at %0d rates.",
                 items_taken, results_checked, rates_written + 1);
        $display("The wave reloaded %0d times; %0d status reads saw a live length counter.",
                 recalcs_seen, live_status);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
